FILE: rtl/tdp_pkg.sv
// Shared types and constants for the trial-division primality tester.
// No dependencies; used by tdp_div and trial_division_prime_test.
`default_nettype none
package tdp_pkg;

  localparam int SMALL_PRIME   = 3;
  localparam int PAIR_OFFSET   = 2;
  localparam int FIRST_DIVISOR = 5;
  localparam int WHEEL_STEP    = 6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/tdp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle while busy; stat.done marks the end of a division.
// Depends on tdp_pkg (div_stat_t).
`default_nettype none
module tdp_div import tdp_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quotient,
  output logic      [W-1:0] remainder,
  output div_stat_t         stat
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    sh      = {rem_r, quo_r[W-1]};
    diff    = sh - {1'b0, divisor};
    ge      = ~diff[W];
    rem_nxt = ge ? diff[W-1:0] : sh[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        cnt_r  <= CW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

FILE: rtl/trial_division_prime_test.sv
// Trial-division primality tester (6k +/- 1 wheel) around one bit-serial divider.
// An item needs one division by 3 and then two divisions per wheel step up to
// sqrt(value); negatives, 0..3 and even values skip the divider. One item at a time.
// The result sits in an output register, so a new beat is taken while it waits.
// Synchronous active-low reset clears the sequencer and drops any pending result.
`default_nettype none
module trial_division_prime_test import tdp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_is_prime
);

  localparam int W = VALUE_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV3  = 5'b00010,
    S_DIVI  = 5'b00100,
    S_DIVI2 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] i_r, i_nxt;
  logic         res_r, res_nxt;
  logic         start_r, start_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_is_prime_r, out_is_prime_nxt;
  logic [W-1:0] divisor;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  div_stat_t    div_stat;
  logic         accept;

  tdp_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (n_r),
    .divisor  (divisor),
    .quotient (quo),
    .remainder(rem),
    .stat     (div_stat)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (state_r)
      S_DIV3:  divisor = W'(SMALL_PRIME);
      S_DIVI2: divisor = i_r + W'(PAIR_OFFSET);
      default: divisor = i_r;
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    i_nxt            = i_r;
    res_nxt          = res_r;
    start_nxt        = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_is_prime_nxt = out_is_prime_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_nxt = in_value;
          if (in_value[W-1] || in_value < W'(2)) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else if (in_value == W'(2) || in_value == W'(3)) begin
            res_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (!in_value[0]) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_DIV3;
          end
        end
      end
      S_DIV3: begin
        if (div_stat.done) begin
          if (rem == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            i_nxt     = W'(FIRST_DIVISOR);
            start_nxt = 1'b1;
            state_nxt = S_DIVI;
          end
        end
      end
      S_DIVI: begin
        if (div_stat.done) begin
          if (i_r > quo) begin
            res_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (rem == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_DIVI2;
          end
        end
      end
      S_DIVI2: begin
        if (div_stat.done) begin
          if (rem == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + W'(WHEEL_STEP);
            start_nxt = 1'b1;
            state_nxt = S_DIVI;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    i_r            <= i_nxt;
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

`ifndef NO_ASSERTIONS
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV3 || state_r == S_DIVI || state_r == S_DIVI2))
    else $error("divider finished outside a division state");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken before the first was judged");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_trial_division_prime_test.sv
`timescale 1ns / 1ps
// Self-checking bench for trial_division_prime_test: directed table, long-hold burst, random values.
// Depends on tdp_pkg and the trial_division_prime_test RTL; predicts each verdict in the bench.
module tb_trial_division_prime_test;
  import tdp_pkg::*;

  localparam int VW         = 32;
  localparam int LIMIT      = 8_000_000;
  localparam int HOLD_LEN   = 400;
  localparam int NUM_RANDOM = 70;
  localparam int NUM_PROBES = 25;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          known;
    logic          verdict;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{32'h8000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0},
    '{32'd0,         1'b1, 1'b0},
    '{32'd1,         1'b1, 1'b0},
    '{32'd2,         1'b1, 1'b1},
    '{32'd3,         1'b1, 1'b1},
    '{32'd4,         1'b1, 1'b0},
    '{32'h7FFF_FFFE, 1'b1, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0},
    '{32'd5,         1'b0, 1'b0},
    '{32'd7,         1'b0, 1'b0},
    '{32'd9,         1'b0, 1'b0},
    '{32'd25,        1'b0, 1'b0},
    '{32'd35,        1'b0, 1'b0},
    '{32'd49,        1'b0, 1'b0},
    '{32'd121,       1'b0, 1'b0},
    '{32'd143,       1'b0, 1'b0},
    '{32'd169,       1'b0, 1'b0},
    '{32'd529,       1'b0, 1'b0},
    '{32'd7919,      1'b0, 1'b0},
    '{32'd65537,     1'b0, 1'b0},
    '{32'd994009,    1'b0, 1'b0},
    '{32'd1000003,   1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0}
  };

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [VW-1:0] in_value;
  logic          out_valid;
  logic          out_stall;
  logic          out_is_prime;

  bit          verdict_q [$];
  int unsigned rx_idx       = 0;
  int unsigned tx_idle;
  int unsigned rx_idle;
  logic        hold_request;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned cycles       = 0;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned primes_seen  = 0;
  int unsigned negatives_sent;

  trial_division_prime_test #(.VALUE_WIDTH(VW)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit prime_verdict(input logic [VW-1:0] v);
    longint unsigned n;
    longint unsigned d;
    if (v[VW-1]) return 1'b0;
    n = v;
    if (n < 2) return 1'b0;
    if (n == 2 || n == SMALL_PRIME) return 1'b1;
    if (n % 2 == 0 || n % SMALL_PRIME == 0) return 1'b0;
    for (d = FIRST_DIVISOR; d <= n / d; d += WHEEL_STEP) begin
      if (n % d == 0 || n % (d + PAIR_OFFSET) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly cheap values; above 2^22 only negatives and multiples of a small prime, so the divider loop stays short.
  function automatic logic [VW-1:0] pick_value();
    int unsigned   r;
    int unsigned   k;
    logic [VW-1:0] v;
    r = $urandom_range(99);
    if (r < 15) begin
      v = $urandom() | 32'h8000_0000;
    end else if (r < 35) begin
      v = $urandom_range(300);
    end else if (r < 75) begin
      v = $urandom_range(65535);
    end else if (r < 90) begin
      case ($urandom_range(5))
        0: k = 2;
        1: k = 3;
        2: k = 5;
        3: k = 7;
        4: k = 11;
        default: k = 13;
      endcase
      v = $urandom_range(32'h7FFF_FFFF / k) * k;
    end else begin
      v = $urandom_range(32'h003F_FFFF);
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_value(input logic [VW-1:0] v, input bit known, input bit verdict);
    bit expected;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected  = known ? verdict : prime_verdict(v);
    verdict_q = {verdict_q, expected};
    if (v[VW-1]) negatives_sent++;
  endtask

  task automatic set_idling(input int unsigned tx, input int unsigned rx);
    tx_idle = tx;
    rx_idle <= rx;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (rx_idx >= verdict_q.size()) begin
        report_mismatch($sformatf("result %0b with nothing pending", out_is_prime));
      end else begin
        if (out_is_prime !== verdict_q[rx_idx])
          report_mismatch($sformatf("is_prime %0b, predicted %0b", out_is_prime,
                                    verdict_q[rx_idx]));
        if (verdict_q[rx_idx]) primes_seen++;
        rx_idx++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               verdict_q.size() - rx_idx);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    negatives_sent = 0;
    tx_idle        = 0;
    rx_idle        <= 0;
    hold_request   <= 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(32, 75);
    for (int i = 0; i < NUM_PROBES; i++)
      send_value(PROBES[i].value, PROBES[i].known, PROBES[i].verdict);

    // hold the result side long enough that the block backs up into its input
    set_idling(0, 0);
    hold_request <= 1'b1;
    for (int i = 0; i < 6; i++)
      send_value($urandom_range(200), 1'b0, 1'b0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 0) set_idling(32, 75);
      else if (i == NUM_RANDOM / 3) set_idling(75, 32);
      else if (i == 2 * NUM_RANDOM / 3) set_idling(0, 0);
      send_value(pick_value(), 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    while (rx_idx < verdict_q.size()) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d verdicts (%0d prime) incl. %0d negative inputs over %0d cycles",
             results_seen, primes_seen, negatives_sent, cycles);
    $display("Covered sign/extreme cases, wheel divisor pairs, a long output hold and three idling mixes");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
